/* sv/ipv4p_pkg.sv */
// Package: character codes, widths and the result type of the IPv4 dotted-decimal parser.
`default_nettype none
package ipv4p_pkg;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [9:0] OCTET_MAX  = 10'd255;
	localparam logic [1:0] DIGITS_MAX = 2'd3;
	localparam logic [1:0] LAST_INDEX = 2'd3;

	localparam int unsigned IN_W  = 8;
	localparam int unsigned OUT_W = 40;

	typedef struct packed {
		logic [7:0] octet_d;
		logic [7:0] octet_c;
		logic [7:0] octet_b;
		logic [7:0] octet_a;
		logic       parse_ok;
	} result_t;

	typedef struct packed {
		logic       fire;
		logic [7:0] char_code;
	} step_t;

endpackage
`default_nettype wire

/* sv/ipv4p_core.sv */
// Parser state: octet index, digit count, accumulator, closed octets, sticky error.
`default_nettype none
module ipv4p_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ipv4p_pkg::step_t step,
	output ipv4p_pkg::result_t    result
);

	logic [9:0] acc_q;
	logic [7:0] fin_q [3];
	logic [1:0] idx_q;
	logic [1:0] cnt_q;
	logic       err_q;

	logic       is_nul;
	logic       is_dot;
	logic       is_digit;
	logic [9:0] acc_next;
	logic       ok;

	assign is_nul   = (step.char_code == ipv4p_pkg::CH_NUL);
	assign is_dot   = (step.char_code == ipv4p_pkg::CH_DOT);
	assign is_digit = (step.char_code >= ipv4p_pkg::CH_ZERO) &&
	                  (step.char_code <= ipv4p_pkg::CH_NINE);
	assign acc_next = (acc_q << 3) + (acc_q << 1) +
	                  {2'b00, step.char_code - ipv4p_pkg::CH_ZERO};
	assign ok       = !err_q && (acc_q <= ipv4p_pkg::OCTET_MAX);

	always_comb begin
		logic [7:0] oct [4];
		for (int i = 0; i < 4; i++) begin
			oct[i] = 8'd0;
		end
		if (ok) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < idx_q) begin
					oct[i] = fin_q[i];
				end
			end
			oct[idx_q] = acc_q[7:0];
		end
		result.parse_ok = ok;
		result.octet_a  = oct[0];
		result.octet_b  = oct[1];
		result.octet_c  = oct[2];
		result.octet_d  = oct[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			idx_q <= '0;
			cnt_q <= '0;
			err_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				fin_q[i] <= '0;
			end
		end else if (step.fire) begin
			if (is_nul) begin
				acc_q <= '0;
				idx_q <= '0;
				cnt_q <= '0;
				err_q <= 1'b0;
				for (int i = 0; i < 3; i++) begin
					fin_q[i] <= '0;
				end
			end else if (!err_q) begin
				if (is_dot) begin
					if (acc_q > ipv4p_pkg::OCTET_MAX || idx_q >= ipv4p_pkg::LAST_INDEX) begin
						err_q <= 1'b1;
					end else begin
						fin_q[idx_q] <= acc_q[7:0];
						idx_q        <= idx_q + 2'd1;
						acc_q        <= '0;
						cnt_q        <= '0;
					end
				end else if (is_digit) begin
					if (cnt_q >= ipv4p_pkg::DIGITS_MAX) begin
						err_q <= 1'b1;
					end else begin
						acc_q <= acc_next;
						cnt_q <= cnt_q + 2'd1;
					end
				end else begin
					err_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* sv/ipv4_dotted_decimal_parser_top.sv */
// Top level of the IPv4 dotted-decimal parser: input register, parser state, result register.
//
//   channel  dir  tdata bits, lowest first              item
//   s_*      in   [7:0] char_code                        one string byte
//   m_*      out  [0] parse_ok, [8:1] octet_a,           one parsed address
//                 [16:9] octet_b, [24:17] octet_c,
//                 [32:25] octet_d, [39:33] zero
//
// One byte per cycle while no result waits unread; each byte is held in the
// input register and folded into the parser state when it advances. A zero
// byte loads the result register, which drives m_tvalid.
// Reset clears the parser state and both valid flags. While a result waits
// unread, the input register holds and s_tready drops once it is full.
`default_nettype none
module ipv4_dotted_decimal_parser_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [ipv4p_pkg::IN_W-1:0]    s_tdata,  // [7:0] char_code
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [ipv4p_pkg::OUT_W-1:0]   m_tdata   // parse_ok, octet_a..octet_d, pad
);

	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 res_valid_q;
	ipv4p_pkg::result_t   res_q;
	ipv4p_pkg::result_t   core_res;
	ipv4p_pkg::step_t     step;
	logic                 adv;
	logic                 emit;

	assign adv      = !res_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;

	assign step.fire      = valid_s1 && adv;
	assign step.char_code = char_s1;
	assign emit           = step.fire && (char_s1 == ipv4p_pkg::CH_NUL);

	ipv4p_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.result (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= core_res;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {7'd0, res_q};

endmodule
`default_nettype wire

/* sv/ipv4p_checker.sv */
// Port checker for the IPv4 dotted-decimal parser, bound to the top level.
`default_nettype none
module ipv4p_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result item changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'd0)
		else $error("failed parse carries nonzero octets");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:33] == 7'd0)
		else $error("result padding not zero");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a waiting result");

endmodule

bind ipv4_dotted_decimal_parser_top ipv4p_checker u_ipv4p_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

/* tb/sv/ipv4_dotted_decimal_parser_top_test.sv */
// Self-checking testbench: streams address strings into the IPv4 parser and checks every result.
`default_nettype none
module ipv4_dotted_decimal_parser_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEC_RADIX   = 10;
	localparam int unsigned BYTE_TARGET = 1700;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned MAX_GAP     = 16;
	localparam int unsigned N_PROBES    = 24;

	localparam ipv4p_pkg::result_t ADDR_FAIL  = '0;
	localparam ipv4p_pkg::result_t ADDR_EMPTY = '{octet_d: 8'd0, octet_c: 8'd0,
		octet_b: 8'd0, octet_a: 8'd0, parse_ok: 1'b1};

	typedef struct packed {
		logic [7:0]         ch;
		logic               pinned;
		ipv4p_pkg::result_t want;
	} probe_t;

	localparam probe_t PROBES [N_PROBES] = '{
		'{ipv4p_pkg::CH_NUL, 1'b1, ADDR_EMPTY},
		'{ipv4p_pkg::CH_ZERO + 8'd2, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_ZERO + 8'd5, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_ZERO + 8'd6, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_NUL, 1'b1, ADDR_FAIL},
		'{ipv4p_pkg::CH_ZERO, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_ZERO, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_ZERO, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_ZERO, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_NUL, 1'b1, ADDR_FAIL},
		'{ipv4p_pkg::CH_DOT, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_DOT, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_DOT, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_DOT, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_NUL, 1'b1, ADDR_FAIL},
		'{8'hFF, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_DOT, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_NUL, 1'b1, ADDR_FAIL},
		'{ipv4p_pkg::CH_ZERO + 8'd2, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_ZERO + 8'd5, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_ZERO + 8'd5, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_DOT, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_NINE, 1'b0, ADDR_FAIL},
		'{ipv4p_pkg::CH_NUL, 1'b0, ADDR_FAIL}
	};

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [ipv4p_pkg::IN_W-1:0]     s_tdata;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [ipv4p_pkg::OUT_W-1:0]    m_tdata;

	logic [9:0]           acc_val;
	logic [7:0]           done_octets [3];
	logic [1:0]           oct_idx;
	logic [1:0]           digit_cnt;
	logic                 bad_text;

	ipv4p_pkg::result_t   addr_q [$];
	logic [7:0]           text_q [$];
	int unsigned          cycle_cnt;
	int unsigned          bytes_sent;
	int unsigned          strings_sent;
	int unsigned          addrs_seen;
	int unsigned          addrs_ok;
	int unsigned          fail_cnt;
	bit                   fast_in;
	bit                   fast_out;

	ipv4_dotted_decimal_parser_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("ipv4_dotted_decimal_parser_top regression: fail");
			$finish;
		end
	end

	function automatic void clear_parse();
		acc_val = '0;
		done_octets[0] = '0;
		done_octets[1] = '0;
		done_octets[2] = '0;
		oct_idx = '0;
		digit_cnt = '0;
		bad_text = 1'b0;
	endfunction

	function automatic bit fold_char(input logic [7:0] ch, output ipv4p_pkg::result_t addr);
		logic [7:0] octs [4];
		addr = '0;
		if (ch == ipv4p_pkg::CH_NUL) begin
			if (!bad_text && acc_val <= ipv4p_pkg::OCTET_MAX) begin
				octs = '{8'd0, 8'd0, 8'd0, 8'd0};
				for (int i = 0; i < 3; i++)
					if (i < oct_idx)
						octs[i] = done_octets[i];
				octs[oct_idx] = acc_val[7:0];
				addr.parse_ok = 1'b1;
				addr.octet_a = octs[0];
				addr.octet_b = octs[1];
				addr.octet_c = octs[2];
				addr.octet_d = octs[3];
			end
			clear_parse();
			return 1'b1;
		end
		if (bad_text)
			return 1'b0;
		if (ch == ipv4p_pkg::CH_DOT) begin
			if (acc_val > ipv4p_pkg::OCTET_MAX || oct_idx >= ipv4p_pkg::LAST_INDEX) begin
				bad_text = 1'b1;
			end else begin
				done_octets[oct_idx] = acc_val[7:0];
				oct_idx = oct_idx + 2'd1;
				acc_val = '0;
				digit_cnt = '0;
			end
		end else if (ch >= ipv4p_pkg::CH_ZERO && ch <= ipv4p_pkg::CH_NINE) begin
			if (digit_cnt >= ipv4p_pkg::DIGITS_MAX) begin
				bad_text = 1'b1;
			end else begin
				acc_val = acc_val * 10'(DEC_RADIX) + 10'(ch - ipv4p_pkg::CH_ZERO);
				digit_cnt = digit_cnt + 2'd1;
			end
		end else begin
			bad_text = 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic send_byte(input logic [7:0] ch, input bit pinned,
		input ipv4p_pkg::result_t want);
		int unsigned gap;
		ipv4p_pkg::result_t addr;
		gap = fast_in ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		if (fold_char(ch, addr)) begin
			strings_sent++;
			addr_q.push_back(pinned ? want : addr);
		end
	endtask

	task automatic push_digits(input int unsigned v, input int unsigned d);
		int unsigned p10;
		for (int k = int'(d) - 1; k >= 0; k--) begin
			p10 = 1;
			for (int j = 0; j < k; j++)
				p10 = p10 * DEC_RADIX;
			text_q.push_back(ipv4p_pkg::CH_ZERO + 8'((v / p10) % DEC_RADIX));
		end
	endtask

	task automatic compose_text();
		int unsigned kind;
		int unsigned n_oct;
		int unsigned v;
		int unsigned d;
		int unsigned r;
		text_q.delete();
		kind = $urandom_range(0, 19);
		if (kind < 16) begin
			n_oct = (kind == 15) ? 5 : $urandom_range(1, 4);
			for (int unsigned o = 0; o < n_oct; o++) begin
				if (o > 0)
					text_q.push_back(ipv4p_pkg::CH_DOT);
				if ($urandom_range(0, 9) != 0) begin
					if (kind == 14 && $urandom_range(0, 1) == 1)
						v = $urandom_range(256, 999);
					else
						v = $urandom_range(0, 255);
					d = $urandom_range(v >= 100 ? 3 : (v >= 10 ? 2 : 1), 3);
					if (kind == 13 && o == 0)
						d = 4;
					push_digits(v, d);
				end
			end
			if (kind == 12)
				text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(1, 255)));
		end else if (kind < 18) begin
			repeat ($urandom_range(1, 8))
				text_q.push_back(8'($urandom_range(1, 255)));
		end else begin
			repeat ($urandom_range(1, 16)) begin
				r = $urandom_range(0, DEC_RADIX);
				text_q.push_back(r == DEC_RADIX ? ipv4p_pkg::CH_DOT :
					ipv4p_pkg::CH_ZERO + 8'(r));
			end
		end
		text_q.push_back(ipv4p_pkg::CH_NUL);
	endtask

	task automatic flag_field(input string field, input logic [7:0] want, input logic [7:0] got);
		fail_cnt++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endtask

	initial begin
		ipv4p_pkg::result_t want;
		ipv4p_pkg::result_t got;
		int unsigned gap;
		m_tready <= 1'b0;
		fast_out = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 7) == 0)
				fast_out = ~fast_out;
			gap = fast_out ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = ipv4p_pkg::result_t'(m_tdata[32:0]);
			addrs_seen++;
			if (addr_q.size() == 0) begin
				fail_cnt++;
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
			end else begin
				want = addr_q.pop_front();
				if (got.parse_ok)
					addrs_ok++;
				if (got.parse_ok !== want.parse_ok)
					flag_field("parse_ok", 8'(want.parse_ok), 8'(got.parse_ok));
				if (got.octet_a !== want.octet_a)
					flag_field("octet_a", want.octet_a, got.octet_a);
				if (got.octet_b !== want.octet_b)
					flag_field("octet_b", want.octet_b, got.octet_b);
				if (got.octet_c !== want.octet_c)
					flag_field("octet_c", want.octet_c, got.octet_c);
				if (got.octet_d !== want.octet_d)
					flag_field("octet_d", want.octet_d, got.octet_d);
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		bytes_sent = 0;
		strings_sent = 0;
		addrs_seen = 0;
		addrs_ok = 0;
		fail_cnt = 0;
		fast_in = 1'b0;
		clear_parse();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_PROBES; i++)
			send_byte(PROBES[i].ch, PROBES[i].pinned, PROBES[i].want);

		s_tvalid <= 1'b0;
		while (addr_q.size() != 0)
			@(posedge clk);
		@(posedge clk);

		while (bytes_sent < BYTE_TARGET) begin
			compose_text();
			fast_in = ($urandom_range(0, 3) == 0);
			foreach (text_q[i])
				send_byte(text_q[i], 1'b0, ADDR_FAIL);
			if ($urandom_range(0, 24) == 0) begin
				s_tvalid <= 1'b0;
				while (addr_q.size() != 0)
					@(posedge clk);
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b0;

		while (addr_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (addr_q.size() != 0) begin
			fail_cnt++;
			$display("%0t: %0d results never arrived", $time, addr_q.size());
		end

		$display("Sent %0d bytes forming %0d strings, incl. empty, oversize and malformed ones.",
			bytes_sent, strings_sent);
		$display("Checked %0d results: %0d accepted addresses, %0d rejected; %0d mismatches.",
			addrs_seen, addrs_ok, addrs_seen - addrs_ok, fail_cnt);
		if (fail_cnt == 0)
			$display("ipv4_dotted_decimal_parser_top regression: pass");
		else
			$display("ipv4_dotted_decimal_parser_top regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
